@@ sv/smt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix transpose: shared package
// Field widths, default sizes, item codes, controller states and the command
// and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package smt_pkg;

	localparam int MAX_DIM_DEF   = 16;
	localparam int MAX_TERMS_DEF = 32;

	localparam int IDX_W   = 5;
	localparam int VAL_W   = 32;
	localparam int ENTRY_W = 2 * IDX_W + VAL_W;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_TERM   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_SCAT,
		ST_DRAIN,
		ST_HDR,
		ST_RD,
		ST_WR
	} state_t;

	typedef struct packed {
		logic take;
		logic pfx;
		logic scat_rd;
		logic out_rd;
		logic out_hdr;
		logic out_ram;
		logic out_last;
	} ctl_cmd_t;

	typedef struct packed {
		logic term_done;
		logic out_free;
	} dp_sts_t;

endpackage

@@ sv/smt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/smt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix transpose: datapath
// Header registers, term store, per-column counts turned into start
// positions, scatter into the result store, and the output register.
// ----------------------------------------------------------------------------
module smt_datapath #(
	parameter int MAX_DIM   = smt_pkg::MAX_DIM_DEF,
	parameter int MAX_TERMS = smt_pkg::MAX_TERMS_DEF,
	localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
	localparam int NW = $clog2(MAX_TERMS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smt_pkg::ctl_cmd_t           cmd,
	input  logic [AW-1:0]               idx,
	input  logic [CW-1:0]               col,
	output smt_pkg::dp_sts_t            sts,
	output logic [NW-1:0]               n,
	input  logic                        kind,
	input  logic [smt_pkg::IDX_W-1:0]   row_index,
	input  logic [smt_pkg::IDX_W-1:0]   col_index,
	input  logic signed [smt_pkg::VAL_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [smt_pkg::IDX_W-1:0]   out_row,
	output logic [smt_pkg::IDX_W-1:0]   out_col,
	output logic signed [smt_pkg::VAL_W-1:0] out_value,
	output logic                        last
);

	import smt_pkg::*;

	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	logic [IDX_W-1:0] hdr_rows_q;
	logic [IDX_W-1:0] hdr_cols_q;
	logic [NW-1:0]    hdr_terms_q;
	logic [NW-1:0]    loaded_q;
	logic [NW-1:0]    sum_q;
	logic [NW-1:0]    cnt_q [MAX_DIM];
	logic             scat_v_s1;

	logic             out_valid_q;
	logic             last_q;
	logic [IDX_W-1:0] out_row_q;
	logic [IDX_W-1:0] out_col_q;
	logic [VAL_W-1:0] out_value_q;

	logic             hdr_take;
	logic             store_en;
	logic             nonpos;
	logic [IDX_W-1:0] rows_sat;
	logic [IDX_W-1:0] cols_sat;
	logic [NW-1:0]    terms_sat;
	logic [IDX_W-1:0] limit;
	logic [IDX_W-1:0] col_sat;
	logic [XW-1:0]    col_sat_x;
	logic [CW-1:0]    in_cidx;
	logic [NW-1:0]    loaded_nx;

	logic [ENTRY_W-1:0] t_rdata;
	logic [ENTRY_W-1:0] o_rdata;
	logic [IDX_W-1:0]   s_row;
	logic [IDX_W-1:0]   s_col;
	logic [VAL_W-1:0]   s_val;
	logic [XW-1:0]      s_col_x;
	logic [CW-1:0]      s_cidx;
	logic [NW-1:0]      s_dst;

	always_comb begin
		hdr_take  = cmd.take && (kind == KIND_HEADER);
		nonpos    = value[VAL_W-1] || (value == '0);
		rows_sat  = (32'(row_index) > 32'(MAX_DIM)) ? IDX_W'(MAX_DIM) : row_index;
		cols_sat  = (32'(col_index) > 32'(MAX_DIM)) ? IDX_W'(MAX_DIM) : col_index;
		terms_sat = (value > 32'(MAX_TERMS)) ? NW'(MAX_TERMS) : NW'(value);
		limit     = (hdr_cols_q == '0) ? '0 : hdr_cols_q - IDX_W'(1);
		col_sat   = (col_index > limit) ? limit : col_index;
		col_sat_x = XW'(col_sat);
		in_cidx   = col_sat_x[CW-1:0];
		store_en  = cmd.take && (kind == KIND_TERM) && (loaded_q < hdr_terms_q);
		loaded_nx = loaded_q + NW'(1);
	end

	assign sts.term_done = store_en && (loaded_nx == hdr_terms_q);
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign n             = hdr_terms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_rows_q  <= '0;
			hdr_cols_q  <= '0;
			hdr_terms_q <= '0;
			loaded_q    <= '0;
			scat_v_s1   <= 1'b0;
		end else begin
			scat_v_s1 <= cmd.scat_rd;
			if (hdr_take) begin
				hdr_rows_q  <= rows_sat;
				hdr_cols_q  <= cols_sat;
				hdr_terms_q <= nonpos ? '0 : terms_sat;
				loaded_q    <= '0;
			end else if (store_en) begin
				loaded_q <= loaded_nx;
			end
		end
	end

	smt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_TERMS)
	) u_term_ram (
		.clk   (clk),
		.we    (store_en),
		.waddr (loaded_q[AW-1:0]),
		.wdata ({row_index, col_sat, value}),
		.re    (cmd.scat_rd),
		.raddr (idx),
		.rdata (t_rdata)
	);

	always_comb begin
		s_row   = t_rdata[ENTRY_W-1 -: IDX_W];
		s_col   = t_rdata[VAL_W +: IDX_W];
		s_val   = t_rdata[VAL_W-1:0];
		s_col_x = XW'(s_col);
		s_cidx  = s_col_x[CW-1:0];
		s_dst   = cnt_q[s_cidx];
	end

	always_ff @(posedge clk) begin
		if (hdr_take) begin
			sum_q <= '0;
			for (int i = 0; i < MAX_DIM; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (store_en) begin
			cnt_q[in_cidx] <= cnt_q[in_cidx] + NW'(1);
		end else if (cmd.pfx) begin
			cnt_q[col] <= sum_q;
			sum_q      <= sum_q + cnt_q[col];
		end else if (scat_v_s1) begin
			cnt_q[s_cidx] <= s_dst + NW'(1);
		end
	end

	smt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_TERMS)
	) u_out_ram (
		.clk   (clk),
		.we    (scat_v_s1),
		.waddr (s_dst[AW-1:0]),
		.wdata ({s_col, s_row, s_val}),
		.re    (cmd.out_rd),
		.raddr (idx),
		.rdata (o_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((hdr_take && nonpos) || cmd.out_hdr || cmd.out_ram) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_take && nonpos) begin
			out_row_q   <= cols_sat;
			out_col_q   <= rows_sat;
			out_value_q <= value;
			last_q      <= 1'b1;
		end else if (cmd.out_hdr) begin
			out_row_q   <= hdr_cols_q;
			out_col_q   <= hdr_rows_q;
			out_value_q <= VAL_W'(hdr_terms_q);
			last_q      <= 1'b0;
		end else if (cmd.out_ram) begin
			out_row_q   <= o_rdata[ENTRY_W-1 -: IDX_W];
			out_col_q   <= o_rdata[VAL_W +: IDX_W];
			out_value_q <= o_rdata[VAL_W-1:0];
			last_q      <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule

@@ sv/smt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix transpose: controller
// Sequences loading, the column prefix pass, the scatter pass and the
// emission of the transposed matrix.
// ----------------------------------------------------------------------------
module smt_ctrl #(
	parameter int MAX_DIM   = smt_pkg::MAX_DIM_DEF,
	parameter int MAX_TERMS = smt_pkg::MAX_TERMS_DEF,
	localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
	localparam int NW = $clog2(MAX_TERMS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  smt_pkg::dp_sts_t  sts,
	input  logic [NW-1:0]     n,
	output smt_pkg::ctl_cmd_t cmd,
	output logic [AW-1:0]     idx,
	output logic [CW-1:0]     col
);

	import smt_pkg::*;

	state_t        state_q;
	state_t        state_nx;
	logic [NW-1:0] idx_q;
	logic [CW-1:0] col_q;
	logic          at_end;
	logic          col_end;

	assign at_end  = (idx_q == n - NW'(1));
	assign col_end = (col_q == CW'(MAX_DIM - 1));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.term_done) state_nx = ST_PREFIX;
			end
			ST_PREFIX: begin
				if (col_end) state_nx = ST_SCAT;
			end
			ST_SCAT: begin
				if (at_end) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nx = ST_HDR;
			end
			ST_HDR: begin
				if (sts.out_free) state_nx = ST_RD;
			end
			ST_RD: begin
				state_nx = ST_WR;
			end
			ST_WR: begin
				if (sts.out_free) state_nx = at_end ? ST_IDLE : ST_RD;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall     = !((state_q == ST_IDLE) && sts.out_free);
		cmd.take     = in_valid && !in_stall;
		cmd.pfx      = (state_q == ST_PREFIX);
		cmd.scat_rd  = (state_q == ST_SCAT);
		cmd.out_rd   = (state_q == ST_RD);
		cmd.out_hdr  = (state_q == ST_HDR) && sts.out_free;
		cmd.out_ram  = (state_q == ST_WR) && sts.out_free;
		cmd.out_last = at_end;
		idx          = idx_q[AW-1:0];
		col          = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					col_q <= '0;
				end
				ST_PREFIX: begin
					col_q <= col_q + CW'(1);
				end
				ST_SCAT: begin
					idx_q <= at_end ? '0 : idx_q + NW'(1);
				end
				ST_WR: begin
					if (sts.out_free) idx_q <= idx_q + NW'(1);
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

endmodule

@@ sv/sparse_matrix_transpose_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix transpose core
// Transposes a sparse matrix given as a header request and term requests.
// ----------------------------------------------------------------------------
// A header request (kind 0) opens a matrix; term requests (kind 1) are taken
// one per cycle while the block is idle and its output is free. A header with
// a count of zero or less returns its header at once. Once the last term of n
// is in, the block runs the column prefix pass and the scatter into the result
// store, then returns the header followed by the results, each read from the
// registered result store and passed on before the next is read; no request
// is taken from the end of loading until the last result leaves.
module sparse_matrix_transpose_core #(
	parameter int MAX_DIM   = smt_pkg::MAX_DIM_DEF,
	parameter int MAX_TERMS = smt_pkg::MAX_TERMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [smt_pkg::IDX_W-1:0]        row_index,
	input  logic [smt_pkg::IDX_W-1:0]        col_index,
	input  logic signed [smt_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [smt_pkg::IDX_W-1:0]        out_row,
	output logic [smt_pkg::IDX_W-1:0]        out_col,
	output logic signed [smt_pkg::VAL_W-1:0] out_value,
	output logic                             last
);

	import smt_pkg::*;

	localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int NW = $clog2(MAX_TERMS + 1);

	ctl_cmd_t      cmd;
	dp_sts_t       sts;
	logic [NW-1:0] n;
	logic [AW-1:0] idx;
	logic [CW-1:0] col;

	smt_ctrl #(
		.MAX_DIM   (MAX_DIM),
		.MAX_TERMS (MAX_TERMS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.n        (n),
		.cmd      (cmd),
		.idx      (idx),
		.col      (col)
	);

	smt_datapath #(
		.MAX_DIM   (MAX_DIM),
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.col       (col),
		.sts       (sts),
		.n         (n),
		.kind      (kind),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.last      (last)
	);

endmodule
